// ===== sv/hfc_pkg.sv =====
// Shared constants, types and helpers for the height-function curvature pipeline.
`default_nettype none
package hfc_pkg;

    localparam int FRAC_BITS = 24;
    localparam int SH_SLOPE  = 32 - FRAC_BITS;
    localparam int SH_CURV   = 60 - FRAC_BITS;

    localparam int NUM_W  = 68 + SH_CURV;
    localparam int DEN_W  = 66;
    localparam int QUO_W  = 59;
    localparam int DIV_ST = QUO_W + 1;
    localparam int ISQ_ST = 33;
    localparam int N_DLY  = DIV_ST + 2;

    localparam int C_IDX  = 4 + DIV_ST;
    localparam int TAP_R  = 3 + ISQ_ST;
    localparam int TAP_U  = TAP_R + 2;
    localparam int TAP_T  = TAP_R + 4;
    localparam int TAP_B  = TAP_R + 6;
    localparam int R_LEN  = TAP_B + 1 - TAP_R;
    localparam int LAT    = C_IDX + TAP_B + 5;
    localparam int N_MUL  = 21;

    localparam logic [QUO_W-1:0] LIM_SLOPE = QUO_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [QUO_W-1:0] LIM_CURV  = {QUO_W{1'b1}};

    localparam logic [31:0] SPACING_RESET = 32'h1000_0000;

    localparam logic [2:0] FUNC_CX  = 3'd0;
    localparam logic [2:0] FUNC_CY  = 3'd1;
    localparam logic [2:0] FUNC_CZ  = 3'd2;
    localparam logic [2:0] FUNC_FWD = 3'd3;
    localparam logic [2:0] FUNC_BWD = 3'd4;

    localparam logic [1:0] REG_SPX = 2'd0;
    localparam logic [1:0] REG_SPY = 2'd1;
    localparam logic [1:0] REG_SPZ = 2'd2;

    typedef struct packed {
        logic [23:0] cid;
        logic        bad;
    } t_side;

    typedef struct packed {
        logic signed [47:0] g1;
        logic signed [47:0] g2;
        logic signed [59:0] g11;
        logic signed [59:0] g22;
        logic signed [59:0] g12;
        logic signed [60:0] gs;
    } t_gset;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] f_sgn(input logic [62:0] m, input logic neg);
        return neg ? -$signed(64'(m)) : $signed(64'(m));
    endfunction

endpackage
`default_nettype wire

// ===== sv/hfc_mul.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
`default_nettype none
module hfc_mul (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic      [127:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[31:0]};
            r_p01 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[63:32]};
            r_p10 <= {32'b0, i_a[63:32]} * {32'b0, i_b[31:0]};
            r_p11 <= {32'b0, i_a[63:32]} * {32'b0, i_b[63:32]};
            r_p   <= 128'(r_p00) + (128'(r_p01) << 32) + (128'(r_p10) << 32)
                   + (128'(r_p11) << 64);
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== sv/hfc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`default_nettype none
module hfc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [hfc_pkg::NUM_W-1:0]  i_num,
    input  wire logic [hfc_pkg::DEN_W-1:0]  i_den,
    output logic      [hfc_pkg::QUO_W-1:0]  o_quo,
    output logic                            o_ovf
);
    localparam int QW = hfc_pkg::QUO_W;
    localparam int DW = hfc_pkg::DEN_W;
    localparam int NW = hfc_pkg::NUM_W;

    logic [DW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [QW-1:0] r_quo [0:QW];
    logic          r_ovf [0:QW];

    logic [DW:0]   c_trial [0:QW-1];
    logic          c_ge    [0:QW-1];
    logic [DW-1:0] n_rem   [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            c_trial[k] = {r_rem[k], r_low[k][QW-1]};
            c_ge[k]    = c_trial[k] >= {1'b0, r_den[k]};
            n_rem[k]   = c_ge[k] ? DW'(c_trial[k] - {1'b0, r_den[k]}) : DW'(c_trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num[NW-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= DW'(i_num[NW-1:QW]) >= i_den;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][QW-2:0], c_ge[k]};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];
endmodule
`default_nettype wire

// ===== sv/hfc_isqrt.sv =====
// Pipelined bit-by-bit inverse square root: largest R with R*R*s <= 2^96.
`default_nettype none
module hfc_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_s,
    output logic      [32:0] o_r
);
    localparam int NS = hfc_pkg::ISQ_ST;

    // e: 2^96 - r*r*s, y: r*s
    logic [96:0] r_e [0:NS-1];
    logic [96:0] r_y [0:NS-1];
    logic [32:0] r_r [0:NS-1];
    logic [63:0] r_s [0:NS-1];

    logic [96:0] n_e [0:NS-1];
    logic [96:0] n_y [0:NS-1];
    logic [32:0] n_r [0:NS-1];
    logic [63:0] n_s [0:NS-1];

    always_comb begin
        logic [96:0]  v_e, v_y;
        logic [32:0]  v_r;
        logic [63:0]  v_s;
        logic [129:0] v_t;
        int           b;
        for (int k = 0; k < NS; k++) begin
            b = NS - 1 - k;
            if (k == 0) begin
                v_e = 97'(1) << 96;
                v_y = '0;
                v_r = '0;
                v_s = i_s;
            end else begin
                v_e = r_e[k-1];
                v_y = r_y[k-1];
                v_r = r_r[k-1];
                v_s = r_s[k-1];
            end
            v_t = (130'(v_y) << (b + 1)) + (130'(v_s) << (2 * b));
            n_s[k] = v_s;
            if (v_t <= 130'(v_e)) begin
                n_e[k] = 97'(130'(v_e) - v_t);
                n_y[k] = v_y + (97'(v_s) << b);
                n_r[k] = v_r | (33'(1) << b);
            end else begin
                n_e[k] = v_e;
                n_y[k] = v_y;
                n_r[k] = v_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_e[k] <= n_e[k];
                r_y[k] <= n_y[k];
                r_r[k] <= n_r[k];
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_r = r_r[NS-1];
endmodule
`default_nettype wire

// ===== sv/height_function_curvature_3d.sv =====
// Top level: stencil derivatives, divides, inverse root and curvature assembly.
//
//  channel  direction  handshake             payload
//  input    in         i_valid / o_stall     func, sign_dir, cell_index, nine heights
//  result   out        o_valid / i_stall     cell_index_out, curvature, saturated
//  config   in         i_cfg_we              i_cfg_idx, i_cfg_data
//
//  One item per cycle while the result side does not stall; the latency is set by the 60-stage derivative
//  dividers, the 33-stage inverse root and the chain of multipliers.
//  Reset clears the valid line and loads all spacings with 1.0.
//  A stall on the result side while a result is valid freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module height_function_curvature_3d (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_func,
    input  wire logic signed [1:0]  i_sign_dir,
    input  wire logic [23:0]        i_cell_index,
    input  wire logic signed [31:0] i_h_center,
    input  wire logic signed [31:0] i_h_left,
    input  wire logic signed [31:0] i_h_right,
    input  wire logic signed [31:0] i_h_near_a,
    input  wire logic signed [31:0] i_h_near_b,
    input  wire logic signed [31:0] i_h_diag_a,
    input  wire logic signed [31:0] i_h_diag_b,
    input  wire logic signed [31:0] i_h_diag_c,
    input  wire logic signed [31:0] i_h_diag_d,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [23:0]             o_cell_index_out,
    output logic signed [31:0]      o_curvature,
    output logic                    o_saturated
);
    localparam int LAT = hfc_pkg::LAT;

    logic en;

    // configuration
    logic [31:0] r_spx, r_spy, r_spz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spx <= hfc_pkg::SPACING_RESET;
            r_spy <= hfc_pkg::SPACING_RESET;
            r_spz <= hfc_pkg::SPACING_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hfc_pkg::REG_SPX: r_spx <= i_cfg_data;
                hfc_pkg::REG_SPY: r_spy <= i_cfg_data;
                hfc_pkg::REG_SPZ: r_spz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid and sideband line
    logic           r_vl [0:LAT-1];
    hfc_pkg::t_side r_sb [0:LAT-1];

    assign o_valid = r_vl[LAT-1];
    assign en      = !(r_vl[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vl[i] <= 1'b0;
        end else if (en) begin
            r_vl[0] <= i_valid;
            for (int i = 1; i < LAT; i++) r_vl[i] <= r_vl[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0].cid <= i_cell_index;
            r_sb[0].bad <= i_func > hfc_pkg::FUNC_BWD;
            for (int i = 1; i < LAT; i++) r_sb[i] <= r_sb[i-1];
        end
    end

    // stage A: input capture
    logic [2:0]         r_a_func;
    logic signed [31:0] r_a_h [0:8];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_func <= i_func;
            r_a_h[0] <= i_h_center;
            r_a_h[1] <= i_h_left;
            r_a_h[2] <= i_h_right;
            r_a_h[3] <= i_h_near_a;
            r_a_h[4] <= i_h_near_b;
            r_a_h[5] <= i_h_diag_a;
            r_a_h[6] <= i_h_diag_b;
            r_a_h[7] <= i_h_diag_c;
            r_a_h[8] <= i_h_diag_d;
        end
    end

    // stage B: stencil combinations and axis selection
    logic signed [36:0] c_n [0:4];
    logic [31:0]        c_d, c_p, c_q;
    always_comb begin
        logic signed [36:0] hc, hl, hr, na, nb, da, db, dc, dd, dr, dn, dk;
        hc = 37'(r_a_h[0]); hl = 37'(r_a_h[1]); hr = 37'(r_a_h[2]);
        na = 37'(r_a_h[3]); nb = 37'(r_a_h[4]);
        da = 37'(r_a_h[5]); db = 37'(r_a_h[6]); dc = 37'(r_a_h[7]); dd = 37'(r_a_h[8]);
        dr = hr - hl;
        dn = db - da;
        dk = dd - dc;
        c_n[0] = dr;
        c_n[2] = hr - (hc <<< 1) + hl;
        case (r_a_func) inside
            hfc_pkg::FUNC_CX, hfc_pkg::FUNC_CY, hfc_pkg::FUNC_CZ: begin
                c_n[1] = nb - na;
                c_n[3] = nb - (hc <<< 1) + na;
                c_n[4] = db - da - dd + dc;
            end
            hfc_pkg::FUNC_FWD: begin
                c_n[1] = -(37'sd3 * hc) + (na <<< 2) - nb;
                c_n[3] = hc - (na <<< 1) + nb;
                c_n[4] = -(37'sd3 * dr) + (dn <<< 2) - dk;
            end
            default: begin
                c_n[1] = (37'sd3 * hc) - (na <<< 2) + nb;
                c_n[3] = hc - (na <<< 1) + nb;
                c_n[4] = (37'sd3 * dr) - (dn <<< 2) + dk;
            end
        endcase
        unique case (r_a_func)
            hfc_pkg::FUNC_CY: begin c_d = r_spy; c_p = r_spx; c_q = r_spz; end
            hfc_pkg::FUNC_CZ: begin c_d = r_spz; c_p = r_spx; c_q = r_spy; end
            default:          begin c_d = r_spx; c_p = r_spy; c_q = r_spz; end
        endcase
        if (c_d == '0) c_d = 32'd1;
        if (c_p == '0) c_p = 32'd1;
        if (c_q == '0) c_q = 32'd1;
    end

    logic [35:0] r_b_mag [0:4];
    logic [4:0]  r_b_neg;
    logic [31:0] r_b_d, r_b_p, r_b_q;
    logic [31:0] r_pq_p [0:1];
    logic [31:0] r_pq_q [0:1];
    logic [4:0]  r_nd [0:hfc_pkg::N_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 5; i++) begin
                r_b_mag[i] <= 36'(hfc_pkg::f_mag(64'(c_n[i])));
                r_b_neg[i] <= c_n[i][36];
            end
            r_b_d <= c_d;
            r_b_p <= c_p;
            r_b_q <= c_q;
            r_pq_p[0] <= r_b_p;
            r_pq_p[1] <= r_pq_p[0];
            r_pq_q[0] <= r_b_q;
            r_pq_q[1] <= r_pq_q[0];
            r_nd[0] <= r_b_neg;
            for (int i = 1; i < hfc_pkg::N_DLY; i++) r_nd[i] <= r_nd[i-1];
        end
    end

    // multipliers
    logic [63:0]  m_a [0:hfc_pkg::N_MUL-1];
    logic [63:0]  m_b [0:hfc_pkg::N_MUL-1];
    logic [127:0] m_p [0:hfc_pkg::N_MUL-1];

    for (genvar gi = 0; gi < hfc_pkg::N_MUL; gi++) begin : g_mul
        hfc_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (m_a[gi]),
            .i_b   (m_b[gi]),
            .o_p   (m_p[gi])
        );
    end

    // dividers
    logic [hfc_pkg::NUM_W-1:0] d_num [0:4];
    logic [hfc_pkg::DEN_W-1:0] d_den [0:4];
    logic [hfc_pkg::QUO_W-1:0] d_quo [0:4];
    logic                      d_ovf [0:4];

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            d_num[i] = hfc_pkg::NUM_W'(m_p[i]) << ((i < 2) ? hfc_pkg::SH_SLOPE
                                                            : hfc_pkg::SH_CURV);
        end
        d_den[0] = hfc_pkg::DEN_W'({r_pq_p[1], 1'b0});
        d_den[1] = hfc_pkg::DEN_W'({r_pq_q[1], 1'b0});
        d_den[2] = hfc_pkg::DEN_W'(m_p[5]);
        d_den[3] = hfc_pkg::DEN_W'(m_p[6]);
        d_den[4] = hfc_pkg::DEN_W'(m_p[7]) << 2;
    end

    for (genvar gd = 0; gd < 5; gd++) begin : g_div
        hfc_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (d_num[gd]),
            .i_den (d_den[gd]),
            .o_quo (d_quo[gd]),
            .o_ovf (d_ovf[gd])
        );
    end

    // stage C: clamp and sign the derivatives
    logic signed [59:0] c_g [0:4];
    always_comb begin
        logic [hfc_pkg::QUO_W-1:0] v_m;
        for (int i = 0; i < 5; i++) begin
            if (i < 2) begin
                v_m = (d_ovf[i] || d_quo[i] > hfc_pkg::LIM_SLOPE) ? hfc_pkg::LIM_SLOPE
                                                                  : d_quo[i];
            end else begin
                v_m = d_ovf[i] ? hfc_pkg::LIM_CURV : d_quo[i];
            end
            c_g[i] = r_nd[hfc_pkg::N_DLY-1][i] ? -$signed(60'(v_m)) : $signed(60'(v_m));
        end
    end

    hfc_pkg::t_gset r_c;
    hfc_pkg::t_gset r_gd [0:hfc_pkg::TAP_B-1];
    hfc_pkg::t_gset n_gd0;

    always_comb begin
        n_gd0    = r_c;
        n_gd0.gs = 61'(r_c.g11) + 61'(r_c.g22);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c.g1  <= 48'(c_g[0]);
            r_c.g2  <= 48'(c_g[1]);
            r_c.g11 <= c_g[2];
            r_c.g22 <= c_g[3];
            r_c.g12 <= c_g[4];
            r_c.gs  <= '0;
            r_gd[0] <= n_gd0;
            for (int i = 1; i < hfc_pkg::TAP_B; i++) r_gd[i] <= r_gd[i-1];
        end
    end

    // slope norm and inverse root
    logic [63:0] r_s;
    logic [32:0] isq_r;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s <= (64'(1) << 32) + 64'(m_p[8][94:32]) + 64'(m_p[9][94:32]);
        end
    end

    hfc_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s   (r_s),
        .o_r   (isq_r)
    );

    // curvature assembly
    logic [32:0]        r_rd [0:hfc_pkg::R_LEN-1];
    logic signed [63:0] r_t0 [0:1];
    logic signed [63:0] r_br;
    logic [2:0]         r_bn;
    logic signed [63:0] c_br;

    always_comb begin
        hfc_pkg::t_gset gb;
        gb = r_gd[hfc_pkg::TAP_B-1];
        c_br = r_t0[1]
             + hfc_pkg::f_sgn(m_p[17][94:32], gb.g11[59])
             + hfc_pkg::f_sgn(m_p[18][94:32], gb.g22[59])
             - (hfc_pkg::f_sgn(m_p[19][94:32], gb.g12[59] ^ gb.g1[47] ^ gb.g2[47]) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd[0] <= isq_r;
            for (int i = 1; i < hfc_pkg::R_LEN; i++) r_rd[i] <= r_rd[i-1];
            r_t0[0] <= hfc_pkg::f_sgn(m_p[16][94:32], r_gd[hfc_pkg::TAP_T-1].gs[60]);
            r_t0[1] <= r_t0[0];
            r_br    <= c_br;
            r_bn    <= {r_bn[1:0], c_br[63]};
        end
    end

    always_comb begin
        hfc_pkg::t_gset gr, gu, gt;
        gr = r_gd[hfc_pkg::TAP_R-1];
        gu = r_gd[hfc_pkg::TAP_U-1];
        gt = r_gd[hfc_pkg::TAP_T-1];
        for (int i = 0; i < 5; i++) begin
            m_a[i] = 64'(r_b_mag[i]);
            m_b[i] = 64'(r_b_d);
        end
        m_a[5]  = 64'(r_b_p);                  m_b[5]  = 64'(r_b_p);
        m_a[6]  = 64'(r_b_q);                  m_b[6]  = 64'(r_b_q);
        m_a[7]  = 64'(r_b_p);                  m_b[7]  = 64'(r_b_q);
        m_a[8]  = hfc_pkg::f_mag(64'(r_c.g1)); m_b[8]  = hfc_pkg::f_mag(64'(r_c.g1));
        m_a[9]  = hfc_pkg::f_mag(64'(r_c.g2)); m_b[9]  = hfc_pkg::f_mag(64'(r_c.g2));
        m_a[10] = hfc_pkg::f_mag(64'(gr.g1));  m_b[10] = 64'(isq_r);
        m_a[11] = hfc_pkg::f_mag(64'(gr.g2));  m_b[11] = 64'(isq_r);
        m_a[12] = 64'(isq_r);                  m_b[12] = 64'(isq_r);
        m_a[13] = 64'(m_p[11][94:32]);         m_b[13] = 64'(m_p[11][94:32]);
        m_a[14] = 64'(m_p[10][94:32]);         m_b[14] = 64'(m_p[10][94:32]);
        m_a[15] = 64'(m_p[10][94:32]);         m_b[15] = 64'(m_p[11][94:32]);
        m_a[16] = hfc_pkg::f_mag(64'(gu.gs));  m_b[16] = 64'(m_p[12][94:32]);
        m_a[17] = hfc_pkg::f_mag(64'(gt.g11)); m_b[17] = 64'(m_p[13][94:32]);
        m_a[18] = hfc_pkg::f_mag(64'(gt.g22)); m_b[18] = 64'(m_p[14][94:32]);
        m_a[19] = hfc_pkg::f_mag(64'(gt.g12)); m_b[19] = 64'(m_p[15][94:32]);
        m_a[20] = hfc_pkg::f_mag(r_br);        m_b[20] = 64'(r_rd[hfc_pkg::R_LEN-1]);
    end

    // rounding and saturation
    logic signed [31:0] r_curv;
    logic               r_sat;
    always_ff @(posedge i_clk) begin
        logic [62:0] v_km;
        logic [47:0] v_m;
        logic        v_pos;
        if (en) begin
            v_km  = m_p[20][94:32];
            v_pos = !r_bn[2] && (v_km != '0);
            v_m   = 48'((64'(v_km) + 64'h8000) >> 16);
            if (r_sb[LAT-2].bad) begin
                r_curv <= '0;
                r_sat  <= 1'b0;
            end else if (v_pos) begin
                if (v_m > 48'h8000_0000) begin
                    r_curv <= 32'sh8000_0000;
                    r_sat  <= 1'b1;
                end else begin
                    r_curv <= 32'(~v_m + 48'd1);
                    r_sat  <= 1'b0;
                end
            end else begin
                if (v_m > 48'h7FFF_FFFF) begin
                    r_curv <= 32'sh7FFF_FFFF;
                    r_sat  <= 1'b1;
                end else begin
                    r_curv <= 32'(v_m);
                    r_sat  <= 1'b0;
                end
            end
        end
    end

    assign o_cell_index_out = r_sb[LAT-1].cid;
    assign o_curvature      = r_curv;
    assign o_saturated      = r_sat;

    // unused mode codes give a clean zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_sb[LAT-1].bad) |-> (o_curvature == 32'sd0 && !o_saturated))
        else $error("unused mode code produced nonzero curvature");

    // clipping only ever lands on a range end
    a_sat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_curvature == 32'sh7FFF_FFFF || o_curvature == 32'sh8000_0000))
        else $error("saturated flag without range-end curvature");

    // inverse root never exceeds 1.0 since s >= 1.0
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vl[hfc_pkg::C_IDX + hfc_pkg::TAP_R] && isq_r[32]) |-> (isq_r[31:0] == '0))
        else $error("inverse root above one");

endmodule
`default_nettype wire
